### rtl/bmr_pkg.sv
// Package for the burst memory responder.
// Holds the error codes, register indexes, field widths and the beat data function.
// No dependencies.
package bmr_pkg;

    // Widths fixed by the register and state definitions.
    localparam int LAT_W      = 10;
    localparam int BEAT_NUM_W = 4;
    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 64;

    // Salt mixed into every synthesized beat word.
    localparam logic [DATA_W-1:0] DATA_SALT = 64'h9e37_79b9_7f4a_7c15;

    // Configuration register indexes.
    localparam logic REG_FIRST_LAT = 1'b0;
    localparam logic REG_GAP_LAT   = 1'b1;

    // Per-tick status reported with every result.
    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_NO_BEAT    = 2'd1,
        ERR_BUSY       = 2'd2,
        ERR_MISALIGNED = 2'd3
    } err_code_t;

    // Data word of the beat at a byte address: (a xor salt) + (a << 1).
    function automatic logic [DATA_W-1:0] synth_word(input logic [ADDR_W-1:0] a);
        logic [DATA_W-1:0] wide;
        wide = {{(DATA_W-ADDR_W){1'b0}}, a};
        return (wide ^ DATA_SALT) + (wide << 1);
    endfunction

endpackage

### rtl/burst_memory_responder.sv
// Top level of the burst memory responder: tick channel, result channel, APB registers.
// Depends on bmr_pkg for error codes, widths and the beat data function.
//
//   Channel   Direction  Handshake          Carries
//   s_        in         s_valid / s_ready  request_fire, request_address, response_fire
//   m_        out        m_valid / m_ready  request_ready, response_valid, response_data,
//                                           error_code
//   APB       in         psel / penable     first_beat_latency, beat_gap_latency
//
// One tick beat is taken per cycle while s_ready is high; its result appears in the output
// register on the next cycle. The burst state registers are updated in the same edge that
// takes an error-free beat, so the rate is set by that single state update path: one beat
// per cycle while s_ready is high. Reset is synchronous and active low; it clears the burst
// state, the latency registers and the output valid. A stalled result holds s_ready low only
// while the output register is full and m_ready is low.
module burst_memory_responder #(
    parameter int BURST_BEATS = 8,
    parameter int BEAT_BYTES  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Tick input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_request_fire,
    input  logic [bmr_pkg::ADDR_W-1:0]     s_request_address,
    input  logic                           s_response_fire,

    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_request_ready,
    output logic                           m_response_valid,
    output logic [bmr_pkg::DATA_W-1:0]     m_response_data,
    output logic [1:0]                     m_error_code,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int LINE_BYTES = BURST_BEATS * BEAT_BYTES;
    localparam logic [bmr_pkg::ADDR_W-1:0] LINE_MASK = bmr_pkg::ADDR_W'(LINE_BYTES - 1);
    localparam logic [bmr_pkg::BEAT_NUM_W-1:0] LAST_BEAT =
        bmr_pkg::BEAT_NUM_W'(BURST_BEATS);

    // Configuration registers.
    logic [bmr_pkg::LAT_W-1:0]      first_lat_reg;
    logic [bmr_pkg::LAT_W-1:0]      gap_lat_reg;

    // Burst state.
    logic                           busy_reg, busy_next;
    logic                           beat_valid_reg, beat_valid_next;
    logic [bmr_pkg::DATA_W-1:0]     word_reg, word_next;
    logic [bmr_pkg::LAT_W-1:0]      count_reg, count_next;
    logic [bmr_pkg::ADDR_W-1:0]     base_reg, base_next;
    logic [bmr_pkg::BEAT_NUM_W-1:0] beat_reg, beat_next;

    // Result register.
    logic                           m_valid_reg;
    logic                           req_ready_reg;
    logic                           resp_valid_reg;
    logic [bmr_pkg::DATA_W-1:0]     data_reg;
    bmr_pkg::err_code_t             err_reg;

    bmr_pkg::err_code_t             err_next;
    logic [bmr_pkg::BEAT_NUM_W-1:0] beat_inc;
    logic [bmr_pkg::ADDR_W-1:0]     beat_offset;
    logic                           s_take;
    logic                           cfg_write;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_take    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // APB: always ready, reads return the addressed latency register.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == bmr_pkg::REG_FIRST_LAT) begin
            prdata = 32'(first_lat_reg);
        end else begin
            prdata = 32'(gap_lat_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_lat_reg <= '0;
            gap_lat_reg   <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == bmr_pkg::REG_FIRST_LAT) begin
                first_lat_reg <= pwdata[bmr_pkg::LAT_W-1:0];
            end else begin
                gap_lat_reg <= pwdata[bmr_pkg::LAT_W-1:0];
            end
        end
    end

    // Next burst state for one tick: response first, then request, then countdown.
    assign beat_inc    = beat_reg + 1'b1;
    assign beat_offset = bmr_pkg::ADDR_W'(beat_inc) * bmr_pkg::ADDR_W'(BEAT_BYTES);

    always_comb begin
        busy_next       = busy_reg;
        beat_valid_next = beat_valid_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        beat_next       = beat_reg;
        err_next        = bmr_pkg::ERR_OK;

        if (s_response_fire) begin
            if (!busy_reg || !beat_valid_reg) begin
                err_next = bmr_pkg::ERR_NO_BEAT;
            end else if (beat_inc >= LAST_BEAT) begin
                // Last beat taken: the burst is over.
                busy_next       = 1'b0;
                beat_valid_next = 1'b0;
                word_next       = '0;
                count_next      = '0;
                base_next       = '0;
                beat_next       = '0;
            end else begin
                beat_next       = beat_inc;
                word_next       = bmr_pkg::synth_word(base_reg + beat_offset);
                beat_valid_next = 1'b0;
                count_next      = gap_lat_reg;
            end
        end

        if (err_next == bmr_pkg::ERR_OK && s_request_fire) begin
            if (busy_next) begin
                err_next = bmr_pkg::ERR_BUSY;
            end else if ((s_request_address & LINE_MASK) != '0) begin
                err_next = bmr_pkg::ERR_MISALIGNED;
            end else begin
                busy_next       = 1'b1;
                beat_valid_next = 1'b0;
                base_next       = s_request_address;
                beat_next       = '0;
                word_next       = bmr_pkg::synth_word(s_request_address);
                count_next      = first_lat_reg;
            end
        end

        // Countdown to the next valid beat.
        if (busy_next && !beat_valid_next) begin
            if (count_next == '0) begin
                beat_valid_next = 1'b1;
            end else begin
                count_next = count_next - 1'b1;
            end
        end
    end

    // State is committed only on an accepted beat without an error.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            beat_valid_reg <= 1'b0;
            word_reg       <= '0;
            count_reg      <= '0;
            base_reg       <= '0;
            beat_reg       <= '0;
        end else if (s_take && err_next == bmr_pkg::ERR_OK) begin
            busy_reg       <= busy_next;
            beat_valid_reg <= beat_valid_next;
            word_reg       <= word_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
            beat_reg       <= beat_next;
        end
    end

    // Result register: outputs show the state held at the start of the tick and its error code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            req_ready_reg  <= !busy_reg;
            resp_valid_reg <= beat_valid_reg;
            data_reg       <= word_reg;
            err_reg        <= err_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_request_ready  = req_ready_reg;
    assign m_response_valid = resp_valid_reg;
    assign m_response_data  = data_reg;
    assign m_error_code     = err_reg;

    // A valid beat only exists inside a burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> !beat_valid_reg)
        else $error("beat valid while no burst is in progress");

    // The countdown has run out whenever a beat is presented.
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_valid_reg |-> count_reg == '0)
        else $error("beat valid with delay count pending");

    // The beat index never reaches the burst length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_reg < LAST_BEAT)
        else $error("beat number out of range");

    // An erroneous tick leaves the burst state untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && err_next != bmr_pkg::ERR_OK |=>
            $stable(busy_reg) && $stable(beat_valid_reg) && $stable(count_reg)
            && $stable(beat_reg) && $stable(base_reg))
        else $error("burst state changed on an error tick");

    // A result never shows a valid beat together with request ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(resp_valid_reg && req_ready_reg))
        else $error("result shows a valid beat while idle");

endmodule

### bench/burst_memory_responder_test.sv
// Self-checking bench for burst_memory_responder: tick beats in, one status beat out per tick.
// A directed table and biased random bursts are checked against a tick-level predictor.
// Depends on bmr_pkg and the burst_memory_responder RTL.
`timescale 1ns / 1ps

module burst_memory_responder_test;

    localparam int BURST_BEATS = 8;
    localparam int BEAT_BYTES  = 8;
    localparam logic [31:0] LINE_MASK = BURST_BEATS * BEAT_BYTES - 1;
    localparam logic [2:0] ADDR_FIRST_LAT = {bmr_pkg::REG_FIRST_LAT, 2'b00};
    localparam logic [2:0] ADDR_GAP_LAT   = {bmr_pkg::REG_GAP_LAT, 2'b00};
    localparam int STUCK_LIMIT = 500;
    localparam logic [9:0] LAT_MAX = 10'd1023;

    // One memory interface tick as seen on the input channel.
    typedef struct packed {
        logic        req;
        logic [31:0] addr;
        logic        resp;
    } tick_t;

    // Status presented for one tick.
    typedef struct packed {
        logic               rdy;
        logic               vld;
        logic [63:0]        data;
        bmr_pkg::err_code_t err;
    } tick_status_t;

    // Directed row: the expected status is typed in only for rows taken in the reset state.
    typedef struct packed {
        tick_t              t;
        logic               typed;
        bmr_pkg::err_code_t err;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_request_fire;
    logic [31:0] s_request_address;
    logic        s_response_fire;
    logic        m_valid;
    logic        m_ready;
    logic        m_request_ready;
    logic        m_response_valid;
    logic [63:0] m_response_data;
    logic [1:0]  m_error_code;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted responder state and latency settings.
    logic [9:0]  lat_first;
    logic [9:0]  lat_gap;
    logic        line_busy;
    logic        beat_ready;
    logic [63:0] beat_data;
    logic [9:0]  wait_count;
    logic [31:0] burst_base;
    logic [3:0]  burst_beat;

    tick_status_t predicted_status[$];
    dir_row_t     dir_rows[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           stuck_cycles = 0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    logic         quiet = 1'b0;

    burst_memory_responder #(
        .BURST_BEATS (BURST_BEATS),
        .BEAT_BYTES  (BEAT_BYTES)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_request_fire    (s_request_fire),
        .s_request_address (s_request_address),
        .s_response_fire   (s_response_fire),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_request_ready   (m_request_ready),
        .m_response_valid  (m_response_valid),
        .m_response_data   (m_response_data),
        .m_error_code      (m_error_code),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Data word of the beat at byte address a.
    function automatic logic [63:0] word_at(input logic [31:0] a);
        return ({32'd0, a} ^ bmr_pkg::DATA_SALT) + {31'd0, a, 1'b0};
    endfunction

    // Advance the predictor by one tick and return the status it presents.
    function automatic tick_status_t responder_tick(input tick_t t);
        tick_status_t st;
        logic         busy_n;
        logic         valid_n;
        logic [63:0]  word_n;
        logic [9:0]   count_n;
        logic [31:0]  base_n;
        logic [3:0]   beat_n;
        busy_n  = line_busy;
        valid_n = beat_ready;
        word_n  = beat_data;
        count_n = wait_count;
        base_n  = burst_base;
        beat_n  = burst_beat;
        st.rdy  = !line_busy;
        st.vld  = beat_ready;
        st.data = beat_data;
        st.err  = bmr_pkg::ERR_OK;

        // The consumer's acceptance is handled before any new request.
        if (t.resp) begin
            if (!line_busy || !beat_ready) begin
                st.err = bmr_pkg::ERR_NO_BEAT;
            end else begin
                beat_n = beat_n + 4'd1;
                if (beat_n >= BURST_BEATS) begin
                    busy_n  = 1'b0;
                    valid_n = 1'b0;
                    word_n  = '0;
                    count_n = '0;
                    base_n  = '0;
                    beat_n  = '0;
                end else begin
                    word_n  = word_at(base_n + 32'(beat_n) * 32'(BEAT_BYTES));
                    valid_n = 1'b0;
                    count_n = lat_gap;
                end
            end
        end

        if (st.err == bmr_pkg::ERR_OK && t.req) begin
            if (busy_n) begin
                st.err = bmr_pkg::ERR_BUSY;
            end else if ((t.addr & LINE_MASK) != 0) begin
                st.err = bmr_pkg::ERR_MISALIGNED;
            end else begin
                busy_n  = 1'b1;
                valid_n = 1'b0;
                base_n  = t.addr;
                beat_n  = '0;
                word_n  = word_at(t.addr);
                count_n = lat_first;
            end
        end

        // An error tick leaves the whole state untouched.
        if (st.err == bmr_pkg::ERR_OK) begin
            if (busy_n && !valid_n) begin
                if (count_n == 0) valid_n = 1'b1;
                else count_n = count_n - 10'd1;
            end
            line_busy  = busy_n;
            beat_ready = valid_n;
            beat_data  = word_n;
            wait_count = count_n;
            burst_base = base_n;
            burst_beat = beat_n;
        end
        return st;
    endfunction

    // Mostly well-formed bursts with random content, plus protocol noise.
    function automatic tick_t pick_tick();
        tick_t t;
        int    r;
        r      = $urandom_range(0, 99);
        t.req  = 1'b0;
        t.resp = 1'b0;
        t.addr = $urandom();
        if (!line_busy) begin
            if (r < 55) begin
                t.req  = 1'b1;
                t.addr = t.addr & ~LINE_MASK;
            end else if (r < 65) begin
                t.req       = 1'b1;
                t.addr[5:0] = 6'($urandom_range(1, 63));
            end else if (r < 72) begin
                t.resp = 1'b1;
                t.req  = 1'($urandom_range(0, 1));
            end
        end else if (beat_ready) begin
            if (r < 60) begin
                t.resp = 1'b1;
                // A new request in the tick of the last beat must not be refused as busy.
                if (burst_beat == BURST_BEATS - 1 && $urandom_range(0, 1) == 1) begin
                    t.req = 1'b1;
                    if ($urandom_range(0, 3) != 0) t.addr = t.addr & ~LINE_MASK;
                end
            end else if (r < 68) begin
                t.req  = 1'b1;
                t.resp = 1'($urandom_range(0, 1));
            end
        end else begin
            if (r < 6) t.resp = 1'b1;
            else if (r < 12) t.req = 1'b1;
        end
        return t;
    endfunction

    // Predict one tick, drive it and hold it until the beat is taken.
    task automatic issue_tick(input tick_t t, input logic typed,
                              input bmr_pkg::err_code_t typed_err);
        tick_status_t st;
        st = responder_tick(t);
        if (typed) predicted_status.push_back('{1'b1, 1'b0, 64'd0, typed_err});
        else predicted_status.push_back(st);
        s_valid           <= 1'b1;
        s_request_fire    <= t.req;
        s_request_address <= t.addr;
        s_response_fire   <= t.resp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] a, input logic [9:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= a;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {22'd0, want}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register read at %0d: expected %h, got %h", a, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Latencies change only once every predicted status has come back.
    task automatic set_latencies(input logic [9:0] first, input logic [9:0] gap);
        while (predicted_status.size() != 0) @(posedge aclk);
        apb_write(ADDR_FIRST_LAT, {22'd0, first});
        apb_write(ADDR_GAP_LAT, {22'd0, gap});
        lat_first = first;
        lat_gap   = gap;
        apb_check(ADDR_FIRST_LAT, first);
        apb_check(ADDR_GAP_LAT, gap);
    endtask

    // Random ticks; a phase never ends while a countdown is still running.
    task automatic run_phase(input int n_ticks, input int gap_p, input int stall_p);
        int k;
        gap_pct   = gap_p;
        stall_pct = stall_p;
        k = 0;
        while (k < n_ticks || (line_busy && !beat_ready)) begin
            issue_tick(pick_tick(), 1'b0, bmr_pkg::ERR_OK);
            k++;
        end
        s_valid <= 1'b0;
    endtask

    task automatic add_row(input logic req, input logic [31:0] addr, input logic resp,
                           input logic typed, input bmr_pkg::err_code_t err);
        dir_rows.push_back('{'{req, addr, resp}, typed, err});
    endtask

    // Result side stalls in random bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 9);
        end
    end

    // Compare each status beat with the oldest prediction.
    always @(posedge aclk) begin : check_status
        tick_status_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (predicted_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status beat %0d arrived with nothing predicted", results_seen);
            end else begin
                want = predicted_status.pop_front();
                if (m_request_ready !== want.rdy || m_response_valid !== want.vld ||
                    m_response_data !== want.data || m_error_code !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status beat %0d: expected rdy=%b vld=%b data=%h err=%0d,",
                                 results_seen, want.rdy, want.vld, want.data, want.err,
                                 " got rdy=%b vld=%b data=%h err=%0d",
                                 m_request_ready, m_response_valid, m_response_data,
                                 m_error_code);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_request_fire    <= 1'b0;
        s_request_address <= '0;
        s_response_fire   <= 1'b0;
        m_ready           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        lat_first  = '0;
        lat_gap    = '0;
        line_busy  = 1'b0;
        beat_ready = 1'b0;
        beat_data  = '0;
        wait_count = '0;
        burst_base = '0;
        burst_beat = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Both latency registers read back as zero out of reset.
        apb_check(ADDR_FIRST_LAT, 10'd0);
        apb_check(ADDR_GAP_LAT, 10'd0);

        // Directed ticks with zero latencies: error codes and their priority, one full
        // burst at the top line, then requests with a response after the burst has ended.
        add_row(1'b0, 32'h0000_0000, 1'b0, 1'b1, bmr_pkg::ERR_OK);
        add_row(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, bmr_pkg::ERR_NO_BEAT);
        add_row(1'b1, 32'h0000_0001, 1'b0, 1'b1, bmr_pkg::ERR_MISALIGNED);
        add_row(1'b1, 32'h0000_0020, 1'b0, 1'b1, bmr_pkg::ERR_MISALIGNED);
        add_row(1'b1, 32'h0000_003F, 1'b1, 1'b1, bmr_pkg::ERR_NO_BEAT);
        add_row(1'b1, 32'hFFFF_FFC0, 1'b0, 1'b1, bmr_pkg::ERR_OK);
        add_row(1'b1, 32'h0000_0000, 1'b0, 1'b0, bmr_pkg::ERR_OK);
        add_row(1'b1, 32'h0000_0040, 1'b1, 1'b0, bmr_pkg::ERR_OK);
        repeat (BURST_BEATS - 1) add_row(1'b0, 32'h0000_0000, 1'b1, 1'b0, bmr_pkg::ERR_OK);
        add_row(1'b1, 32'h0000_0040, 1'b1, 1'b0, bmr_pkg::ERR_OK);
        add_row(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, bmr_pkg::ERR_OK);
        add_row(1'b0, 32'h0000_0000, 1'b0, 1'b0, bmr_pkg::ERR_OK);
        gap_pct   = 20;
        stall_pct = 20;
        foreach (dir_rows[i]) issue_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].err);
        s_valid <= 1'b0;

        // Random phases over several latency settings, the extremes among them.
        // Each phase, the one at the largest latencies too, runs on until no countdown is running.
        set_latencies(10'd0, 10'd0);
        run_phase(250, 15, 15);
        set_latencies(10'd3, 10'd1);
        run_phase(200, 40, 40);
        set_latencies(LAT_MAX, LAT_MAX);
        run_phase(100, 10, 10);
        set_latencies(10'd1, 10'd0);
        quiet = 1'b1;
        run_phase(100, 0, 0);

        while (predicted_status.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bmr_pkg.sv
rtl/burst_memory_responder.sv
bench/burst_memory_responder_test.sv
